// File: rtl/plr_pkg.sv
// plr_pkg: shared types, register codes and saturation helper for the
// periodic laplacian relaxation unit; no dependencies
`default_nettype none
package plr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int SUM_W      = 56;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_TERM   = 3'd0,
    CFG_FIELD_GAIN  = 3'd1,
    CFG_STEP_X      = 3'd2,
    CFG_STEP_Y      = 3'd3,
    CFG_ROWS_IN_USE = 3'd4,
    CFG_COLS_IN_USE = 3'd5
  } cfg_idx_t;

  localparam logic signed [17:0] RST_BIAS_TERM  = 18'sd0;
  localparam logic [30:0]        RST_FIELD_GAIN = 31'd8738;
  localparam logic [30:0]        RST_STEP_X     = 31'd655;
  localparam logic [30:0]        RST_STEP_Y     = 31'd655;
  localparam logic [8:0]         RST_ROWS       = 9'd256;
  localparam logic [8:0]         RST_COLS       = 9'd256;

  typedef struct packed {
    logic               is_query;
    logic signed [31:0] field;
    logic signed [31:0] drive;
    logic               clip;
  } work_t;

  localparam int WORK_W = $bits(work_t);

  typedef struct packed {
    logic               clip;
    logic signed [31:0] value;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t s;
    s.clip = !((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]));
    if (s.clip) begin
      s.value = v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      s.value = v[31:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/plr_if.sv
// plr_in_if / plr_out_if: valid-ready channels of the relaxation unit
// depends on nothing
`default_nettype none
interface plr_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [7:0]         row;
  logic [7:0]         col;
  logic signed [31:0] field_value;
  logic signed [31:0] conc_a;
  logic signed [31:0] conc_b;
  modport source(output valid, mode, row, col, field_value, conc_a, conc_b, input ready);
  modport sink(input valid, mode, row, col, field_value, conc_a, conc_b, output ready);
endinterface

interface plr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] updated_field;
  logic               saturated;
  modport source(output valid, updated_field, saturated, input ready);
  modport sink(input valid, updated_field, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/plr_front.sv
// plr_front: accepts words, range checks, builds wrapped neighbour addresses
// and the drive value of loads; uses plr_pkg and plr_in_if
`default_nettype none
module plr_front #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int AW       = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  plr_in_if.sink                             in_ch,
  input  wire logic signed [17:0]            bias_term,
  input  wire logic [30:0]                   field_gain,
  input  wire logic [8:0]                    rows_in_use,
  input  wire logic [8:0]                    cols_in_use,
  input  wire logic                          q_full,
  output logic                               push,
  output logic [5*AW+plr_pkg::WORK_W-1:0]    push_data
);

  logic [8:0] nr, nc;
  logic [8:0] row9, col9, rp, rm, cp, cm;
  logic       in_range, accept;
  logic [4:0][AW-1:0] addr_c;
  logic signed [63:0] prod_c;
  logic signed [plr_pkg::SUM_W-1:0] dsum;
  plr_pkg::sat_t dsat;
  plr_pkg::work_t work;

  logic               s1_valid_r;
  logic               s1_query_r;
  logic [4:0][AW-1:0] s1_addr_r;
  logic signed [31:0] s1_field_r;
  logic signed [63:0] s1_prod_r;
  logic signed [32:0] s1_diff_r;

  function automatic logic [AW-1:0] flat_addr(input logic [8:0] r, input logic [8:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  always_comb begin
    if (rows_in_use == 9'd0) begin
      nr = 9'd1;
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      nr = 9'(MAX_ROWS);
    end else begin
      nr = rows_in_use;
    end
    if (cols_in_use == 9'd0) begin
      nc = 9'd1;
    end else if (int'(cols_in_use) > MAX_COLS) begin
      nc = 9'(MAX_COLS);
    end else begin
      nc = cols_in_use;
    end
  end

  assign row9     = {1'b0, in_ch.row};
  assign col9     = {1'b0, in_ch.col};
  assign in_range = (row9 < nr) && (col9 < nc);
  assign rp       = (row9 + 9'd1 == nr) ? 9'd0 : row9 + 9'd1;
  assign rm       = (row9 == 9'd0) ? nr - 9'd1 : row9 - 9'd1;
  assign cp       = (col9 + 9'd1 == nc) ? 9'd0 : col9 + 9'd1;
  assign cm       = (col9 == 9'd0) ? nc - 9'd1 : col9 - 9'd1;

  // centre, up, down, left, right
  assign addr_c[0] = flat_addr(row9, col9);
  assign addr_c[1] = flat_addr(rp, col9);
  assign addr_c[2] = flat_addr(rm, col9);
  assign addr_c[3] = flat_addr(row9, cm);
  assign addr_c[4] = flat_addr(row9, cp);

  assign prod_c = in_ch.field_value * $signed({1'b0, field_gain});

  assign push        = s1_valid_r && !q_full;
  assign in_ch.ready = !s1_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= in_range;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (accept) begin
        s1_query_r <= in_ch.mode;
        s1_addr_r  <= addr_c;
        s1_field_r <= in_ch.field_value;
        s1_prod_r  <= prod_c;
        s1_diff_r  <= 33'(in_ch.conc_b) - 33'(in_ch.conc_a);
      end
    end
  end

  // floor of the q16 product is an arithmetic shift
  assign dsum = plr_pkg::SUM_W'(bias_term) + plr_pkg::SUM_W'(s1_prod_r >>> 16)
              + plr_pkg::SUM_W'(s1_diff_r);
  assign dsat = plr_pkg::sat32(dsum);

  always_comb begin
    work.is_query = s1_query_r;
    work.field    = s1_field_r;
    work.drive    = dsat.value;
    work.clip     = dsat.clip;
  end

  assign push_data = {s1_addr_r, work};

endmodule
`default_nettype wire

// File: rtl/plr_queue.sv
// plr_queue: short first-in first-out queue of work words between front and back
// uses plr_pkg for its depth
`default_nettype none
module plr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  localparam int PW = $clog2(plr_pkg::QUEUE_DEPTH);

  logic [W-1:0]  slot_r [plr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full     = (count_r == (PW+1)'(plr_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        slot_r[wr_ptr_r] <= push_data;
        wr_ptr_r         <= wr_ptr_r + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/plr_back.sv
// plr_back: point store and query sequencer with the stencil arithmetic
// uses plr_pkg and plr_out_if
`default_nettype none
module plr_back #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int AW       = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [5*AW+plr_pkg::WORK_W-1:0]   pop_data,
  input  wire logic                              empty,
  output logic                                   pop,
  input  wire logic [30:0]                       step_x,
  input  wire logic [30:0]                       step_y,
  plr_out_if.source                              out_ch
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] drive;
    logic signed [31:0] field;
  } mem_word_t;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_LAP, ST_MUL, ST_SUM} state_t;

  mem_word_t          mem [DEPTH];
  mem_word_t          rd_q;
  mem_word_t          wr_word;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;

  logic [4:0][AW-1:0] pop_addr;
  plr_pkg::work_t     pop_work;

  state_t             state_r;
  logic [2:0]         cnt_r;
  logic [4:0][AW-1:0] addr_r;
  logic signed [31:0] drv_r [5];
  logic [4:0]         clp_r;
  logic signed [31:0] field_c_r;
  logic signed [33:0] lapx_r, lapy_r;
  logic               clip_or_r;
  logic signed [49:0] hx_r, hy_r;
  logic [46:0]        lx_r, ly_r;
  logic               out_valid_r;
  logic signed [31:0] out_field_r;
  logic               out_sat_r;

  logic signed [plr_pkg::SUM_W-1:0] total;
  plr_pkg::sat_t      tsat;
  logic               out_free;

  assign {pop_addr, pop_work} = pop_data;
  assign pop      = (state_r == ST_IDLE) && !empty;
  assign mem_we   = pop && !pop_work.is_query;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    wr_word.clip  = pop_work.clip;
    wr_word.drive = pop_work.drive;
    wr_word.field = pop_work.field;
    if (state_r == ST_READ && cnt_r < 3'd5) begin
      mem_addr = addr_r[cnt_r];
    end else begin
      mem_addr = pop_addr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_word;
    end
    rd_q <= mem[mem_addr];
  end

  assign total = plr_pkg::SUM_W'(field_c_r) + plr_pkg::SUM_W'(hx_r) + plr_pkg::SUM_W'(hy_r)
               + plr_pkg::SUM_W'({1'b0, lx_r[46:16]}) + plr_pkg::SUM_W'({1'b0, ly_r[46:16]});
  assign tsat  = plr_pkg::sat32(total);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_SUM) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop && pop_work.is_query) begin
            addr_r  <= pop_addr;
            cnt_r   <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          for (int k = 0; k < 5; k++) begin
            if (cnt_r == 3'(k + 1)) begin
              drv_r[k] <= rd_q.drive;
              clp_r[k] <= rd_q.clip;
            end
          end
          if (cnt_r == 3'd1) begin
            field_c_r <= rd_q.field;
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd5) begin
            state_r <= ST_LAP;
          end
        end
        ST_LAP: begin
          lapx_r    <= 34'(drv_r[1]) + 34'(drv_r[2]) - (34'(drv_r[0]) <<< 1);
          lapy_r    <= 34'(drv_r[3]) + 34'(drv_r[4]) - (34'(drv_r[0]) <<< 1);
          clip_or_r <= |clp_r;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          // lap = hi * 2^16 + lo, so floor(lap*s/2^16) = hi*s + floor(lo*s/2^16)
          hx_r    <= $signed(lapx_r[33:16]) * $signed({1'b0, step_x});
          hy_r    <= $signed(lapy_r[33:16]) * $signed({1'b0, step_y});
          lx_r    <= lapx_r[15:0] * step_x;
          ly_r    <= lapy_r[15:0] * step_y;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_field_r <= tsat.value;
            out_sat_r   <= tsat.clip || clip_or_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.updated_field = out_field_r;
  assign out_ch.saturated     = out_sat_r;

endmodule
`default_nettype wire

// File: rtl/periodic_laplacian_relaxation_unit.sv
// periodic_laplacian_relaxation_unit: top level, configuration registers and
// the front, queue and back parts; uses plr_pkg, plr_if, plr_front, plr_queue, plr_back
//
// usage:
//   in_ch carries one word per point: mode 0 loads field and concentrations,
//   mode 1 queries the relaxed field of the point. out_ch returns one word per
//   in-range query, in order; loads and out-of-range points return nothing.
//   cfg_we/cfg_index/cfg_data write a register; write only while idle (user's duty).
//   load the whole grid before the first query.
// flow:
//   the front takes a word per cycle into a four-entry queue while the queue
//   is not full. a load costs the back one store write. the back takes a query
//   from the queue, makes five reads of the single-ported point store, then
//   does stencil, multiply and sum; it pops no new word until its result is registered.
// reset:
//   rst_n low clears the queue, the sequencer and the registers to defaults;
//   the point store is not cleared.
// stall:
//   the result waits in the output register; the back holds the next query
//   at its sum step while the front keeps filling the queue.
`default_nettype none
module periodic_laplacian_relaxation_unit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  plr_in_if.sink                              in_ch,
  plr_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [plr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [plr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int QW = 5 * AW + plr_pkg::WORK_W;

  logic signed [17:0] bias_term_r;
  logic [30:0]        field_gain_r, step_x_r, step_y_r;
  logic [8:0]         rows_r, cols_r;

  logic          push, pop, q_full, q_empty;
  logic [QW-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_term_r  <= plr_pkg::RST_BIAS_TERM;
      field_gain_r <= plr_pkg::RST_FIELD_GAIN;
      step_x_r     <= plr_pkg::RST_STEP_X;
      step_y_r     <= plr_pkg::RST_STEP_Y;
      rows_r       <= plr_pkg::RST_ROWS;
      cols_r       <= plr_pkg::RST_COLS;
    end else if (cfg_we) begin
      case (cfg_index)
        plr_pkg::CFG_BIAS_TERM:   bias_term_r  <= cfg_data[17:0];
        plr_pkg::CFG_FIELD_GAIN:  field_gain_r <= cfg_data;
        plr_pkg::CFG_STEP_X:      step_x_r     <= cfg_data;
        plr_pkg::CFG_STEP_Y:      step_y_r     <= cfg_data;
        plr_pkg::CFG_ROWS_IN_USE: rows_r       <= cfg_data[8:0];
        plr_pkg::CFG_COLS_IN_USE: cols_r       <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  plr_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .AW(AW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .bias_term   (bias_term_r),
    .field_gain  (field_gain_r),
    .rows_in_use (rows_r),
    .cols_in_use (cols_r),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  plr_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  plr_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .AW(AW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_data (pop_data),
    .empty    (q_empty),
    .pop      (pop),
    .step_x   (step_x_r),
    .step_y   (step_y_r),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// File: rtl/plr_checker.sv
// plr_checker: port-level assertions for the relaxation unit, bound to the top
// level; depends on periodic_laplacian_relaxation_unit
`default_nettype none
module plr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_updated_field,
  input wire logic        out_saturated
);

  logic [31:0] pend_r;
  logic        in_q, out_acc;

  assign in_q    = in_valid && in_ready && in_mode;
  assign out_acc = out_valid && out_ready;

  // queries accepted minus results taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_q && !out_acc) begin
      pend_r <= pend_r + 32'd1;
    end else if (!in_q && out_acc && pend_r != '0) begin
      pend_r <= pend_r - 32'd1;
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result word right after reset");

  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0) else $error("result word without a pending query");

  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result word dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_updated_field) && $stable(out_saturated))
    else $error("result payload changed while stalled");

endmodule

bind periodic_laplacian_relaxation_unit plr_checker u_plr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_mode           (in_ch.mode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_updated_field (out_ch.updated_field),
  .out_saturated     (out_ch.saturated)
);
`default_nettype wire

// File: tb/tb_periodic_laplacian_relaxation_unit.sv
// tb_periodic_laplacian_relaxation_unit: self-checking bench for the periodic
// five-point relaxation unit; predicts every in-range query result and checks it in order
// depends on plr_pkg, plr_if and periodic_laplacian_relaxation_unit
`timescale 1ns / 100ps
module tb_periodic_laplacian_relaxation_unit;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int GRID_MAX    = 256;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 30;

  typedef struct {
    logic       mode;
    logic [7:0] row;
    logic [7:0] col;
    int         fv;
    int         ca;
    int         cb;
  } point_word_t;

  typedef struct {
    int   value;
    logic sat;
  } relaxed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [plr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [plr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  plr_in_if in_ch();
  plr_out_if out_ch();

  periodic_laplacian_relaxation_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  point_word_t pending[$];
  relaxed_t    relaxed_q[$];

  int   field_mem [GRID_MAX*GRID_MAX];
  int   drive_mem [GRID_MAX*GRID_MAX];
  logic dclip_mem [GRID_MAX*GRID_MAX];

  longint     m_bias = 0;
  logic [30:0] m_gain = 31'd8738;
  logic [30:0] m_sx = 31'd655;
  logic [30:0] m_sy = 31'd655;
  logic [8:0]  m_rows = 9'd256;
  logic [8:0]  m_cols = 9'd256;

  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.field_value = '0;
    in_ch.conc_a = '0;
    in_ch.conc_b = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int eff_dim(logic [8:0] r);
    if (r == 0) return 1;
    return (r > GRID_MAX) ? GRID_MAX : int'(r);
  endfunction

  function automatic longint q_mul(longint a, logic [30:0] b);
    logic signed [79:0] wa, wb, p;
    wa = a;
    wb = {49'd0, b};
    p = wa * wb;
    return longint'(p >>> 16);
  endfunction

  function automatic int clip32(longint v, inout logic c);
    if (v > 64'sd2147483647) begin
      c = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      c = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic void relax_predict(point_word_t w);
    int nr, nc, r, c, rp, rm, cp, cm, i0, iu, id, il, ir;
    longint d, lx, ly, res;
    logic cl;
    relaxed_t e;
    nr = eff_dim(m_rows);
    nc = eff_dim(m_cols);
    r = w.row;
    c = w.col;
    cl = 1'b0;
    if (r >= nr || c >= nc) return;
    i0 = r * GRID_MAX + c;
    if (w.mode == MODE_LOAD) begin
      d = m_bias + q_mul(longint'(w.fv), m_gain) + (longint'(w.cb) - longint'(w.ca));
      field_mem[i0] = w.fv;
      drive_mem[i0] = clip32(d, cl);
      dclip_mem[i0] = cl;
      return;
    end
    rp = (r + 1 == nr) ? 0 : r + 1;
    rm = (r == 0) ? nr - 1 : r - 1;
    cp = (c + 1 == nc) ? 0 : c + 1;
    cm = (c == 0) ? nc - 1 : c - 1;
    iu = rp * GRID_MAX + c;
    id = rm * GRID_MAX + c;
    il = r * GRID_MAX + cm;
    ir = r * GRID_MAX + cp;
    lx = longint'(drive_mem[iu]) + drive_mem[id] - 2 * longint'(drive_mem[i0]);
    ly = longint'(drive_mem[il]) + drive_mem[ir] - 2 * longint'(drive_mem[i0]);
    res = longint'(field_mem[i0]) + q_mul(lx, m_sx) + q_mul(ly, m_sy);
    e.value = clip32(res, cl);
    e.sat = cl | dclip_mem[i0] | dclip_mem[iu] | dclip_mem[id] | dclip_mem[il] | dclip_mem[ir];
    relaxed_q.push_back(e);
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        relax_predict(pending[0]);
        pending.pop_front();
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending[0].mode;
        in_ch.row <= pending[0].row;
        in_ch.col <= pending[0].col;
        in_ch.field_value <= pending[0].fv;
        in_ch.conc_a <= pending[0].ca;
        in_ch.conc_b <= pending[0].cb;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  int rcv_cnt = 0;
  int rcv_mode = 0;
  int hold_left = 0;
  logic hold1_done = 1'b0;
  logic hold2_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (relaxed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %h sat %b", out_ch.updated_field,
                                     out_ch.saturated);
        end else begin
          if (out_ch.updated_field !== relaxed_q[0].value ||
              out_ch.saturated !== relaxed_q[0].sat) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h sat %b, got %h sat %b", relaxed_q[0].value,
                       relaxed_q[0].sat, out_ch.updated_field, out_ch.saturated);
          end
          relaxed_q.pop_front();
        end
      end
      rcv_cnt++;
      if (rcv_cnt % 100 == 0) rcv_mode = $urandom_range(0, 3);
      if (!hold1_done && results_seen >= 150) begin
        hold1_done = 1'b1;
        hold_left = 400;
      end
      if (!hold2_done && results_seen >= 300) begin
        hold2_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rcv_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (rcv_cnt % 7 < 3);
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int rnd_q();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return -1;
      4, 5, 6: return $urandom_range(0, 2097152) - 1048576;
      default: return $urandom();
    endcase
  endfunction

  function automatic int rnd_rate();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(0, 131072);
      default: return $urandom() & 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic push_word(logic m, int r, int c, int f, int a, int b);
    point_word_t w;
    w.mode = m;
    w.row = r[7:0];
    w.col = c[7:0];
    w.fv = f;
    w.ca = a;
    w.cb = b;
    pending.push_back(w);
  endtask

  task automatic drain();
    while (pending.size() != 0 || relaxed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(plr_pkg::cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[plr_pkg::CFG_DATA_W-1:0];
    case (idx)
      plr_pkg::CFG_BIAS_TERM:   m_bias = longint'($signed(val[17:0]));
      plr_pkg::CFG_FIELD_GAIN:  m_gain = val[30:0];
      plr_pkg::CFG_STEP_X:      m_sx = val[30:0];
      plr_pkg::CFG_STEP_Y:      m_sy = val[30:0];
      plr_pkg::CFG_ROWS_IN_USE: m_rows = val[8:0];
      plr_pkg::CFG_COLS_IN_USE: m_cols = val[8:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int rows, int cols, int bias, int gain, int sx, int sy);
    drain();
    cfg_write(plr_pkg::CFG_ROWS_IN_USE, rows);
    cfg_write(plr_pkg::CFG_COLS_IN_USE, cols);
    cfg_write(plr_pkg::CFG_BIAS_TERM, bias);
    cfg_write(plr_pkg::CFG_FIELD_GAIN, gain);
    cfg_write(plr_pkg::CFG_STEP_X, sx);
    cfg_write(plr_pkg::CFG_STEP_Y, sy);
  endtask

  task automatic load_grid();
    for (int r = 0; r < eff_dim(m_rows); r++)
      for (int c = 0; c < eff_dim(m_cols); c++)
        push_word(MODE_LOAD, r, c, rnd_q(), rnd_q(), rnd_q());
  endtask

  task automatic random_queries(int n, int noise);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise) begin
        push_word(1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255),
                  rnd_q(), rnd_q(), rnd_q());
      end else if ($urandom_range(0, 9) == 0) begin
        push_word(MODE_LOAD, $urandom_range(0, eff_dim(m_rows) - 1),
                  $urandom_range(0, eff_dim(m_cols) - 1), rnd_q(), rnd_q(), rnd_q());
      end else begin
        push_word(MODE_QUERY, $urandom_range(0, eff_dim(m_rows) - 1),
                  $urandom_range(0, eff_dim(m_cols) - 1), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    int fvals[9];
    fvals = '{32'h8000_0000, 32'h7FFF_FFFF, 0, -1, 1, 32'h0001_0000, -65536, 12345, -999};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed 3x3 grid with extreme values and out-of-range points
    set_all(3, 3, 65536, 8738, 655, 655);
    for (int i = 0; i < 9; i++)
      push_word(MODE_LOAD, i / 3, i % 3, fvals[i], (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                (i % 3 == 0) ? 32'h7FFF_FFFF : -(i * 4096));
    push_word(MODE_LOAD, 3, 0, 1, 2, 3);
    push_word(MODE_LOAD, 255, 255, -1, -1, -1);
    push_word(MODE_QUERY, 0, 255, 0, 0, 0);
    push_word(MODE_QUERY, 3, 1, 0, 0, 0);
    for (int i = 0; i < 9; i++) push_word(MODE_QUERY, i / 3, i % 3, 0, 0, 0);
    drain();
    // drive values keep the old bias and gain
    cfg_write(plr_pkg::CFG_BIAS_TERM, -65536);
    cfg_write(plr_pkg::CFG_FIELD_GAIN, 32'h7FFF_FFFF);
    for (int i = 0; i < 4; i++) push_word(MODE_QUERY, i % 3, (i + 1) % 3, 0, 0, 0);

    // zero rows acts as one, full column count
    set_all(0, 256, -65536, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    load_grid();
    random_queries(30, 10);

    // oversized rows clamps, zero columns acts as one
    set_all(511, 0, 0, 0, 32'h7FFF_FFFF, 0);
    load_grid();
    random_queries(30, 10);

    // exact full row count
    set_all(256, 1, 4096, 65536, 2048, 2048);
    load_grid();
    random_queries(30, 10);

    // random phases
    for (int p = 0; p < 6; p++) begin
      set_all($urandom_range(3, 10), $urandom_range(3, 10),
              $urandom_range(0, 131072) - 65536, rnd_rate(), rnd_rate(), rnd_rate());
      load_grid();
      random_queries(30, 10);
      drain();
      cfg_write(plr_pkg::CFG_BIAS_TERM, $urandom_range(0, 131072) - 65536);
      cfg_write(plr_pkg::CFG_FIELD_GAIN, rnd_rate());
      cfg_write(plr_pkg::CFG_STEP_X, rnd_rate());
      cfg_write(plr_pkg::CFG_STEP_Y, rnd_rate());
      random_queries(30, 10);
    end

    drain();
    if (errors == 0 && relaxed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
